// ===== sv/plic_pkg.sv =====
// Shared constants and controller/datapath interface types for the interrupt controller.
package plic_pkg;

  localparam int unsigned SOURCES  = 64;
  localparam int unsigned CONTEXTS = 8;
  localparam int unsigned SRC_W    = $clog2(SOURCES);
  localparam int unsigned CTX_W    = $clog2(CONTEXTS);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OFF_W    = 26;
  localparam int unsigned KIND_W   = 2;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LEVEL = 2'd2;

  // Low 12 bits of a context register offset.
  localparam logic [11:0] CTX_THRESHOLD = 12'h000;
  localparam logic [11:0] CTX_CLAIM     = 12'h004;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic look;
    logic exec;
    logic step;
    logic finish;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_req;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

// ===== sv/plic_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module plic_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/plic_dp.sv =====
// Datapath: register file, priority memory, scan comparators and result register.
module plic_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  plic_pkg::cmd_t                 cmd_i,
  output plic_pkg::status_t              status_o,
  input  logic [plic_pkg::KIND_W-1:0]    kind_i,
  input  logic [plic_pkg::OFF_W-1:0]     offset_i,
  input  logic [plic_pkg::DATA_W-1:0]    write_data_i,
  input  logic [plic_pkg::SRC_W-1:0]     source_i,
  input  logic                           level_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [plic_pkg::DATA_W-1:0]    read_data_o,
  output logic [plic_pkg::CONTEXTS-1:0]  irq_lines_o
);
  import plic_pkg::*;

  typedef enum logic [1:0] {
    SCAN_FULL,
    SCAN_CTX,
    SCAN_CLAIM,
    SCAN_NOTIFY
  } scan_mode_e;

  // Captured request.
  logic [KIND_W-1:0] kind_q;
  logic [OFF_W-1:0]  off_q;
  logic [DATA_W-1:0] wd_q;
  logic [SRC_W-1:0]  src_q;
  logic              lvl_q;

  // Architectural state.
  logic [SOURCES-1:0]  prio_vld_q, prio_vld_d;
  logic [SOURCES-1:0]  pend_q, pend_d;
  logic [SOURCES-1:0]  raised_q, raised_d;
  logic [SOURCES-1:0]  en_q [CONTEXTS];
  logic [SOURCES-1:0]  en_d [CONTEXTS];
  logic [DATA_W-1:0]   thr_q [CONTEXTS];
  logic [DATA_W-1:0]   thr_d [CONTEXTS];
  logic [CONTEXTS-1:0] line_q, line_d;

  // Scan state.
  logic [SRC_W:0]      cnt_q, cnt_d;
  logic                ev_q, ev_d;
  scan_mode_e          mode_q, mode_d;
  logic [CTX_W-1:0]    sc_ctx_q, sc_ctx_d;
  logic [SOURCES-1:0]  nmask_q, nmask_d;
  logic [CONTEXTS-1:0] cmask_q, cmask_d;
  logic [1:0]          hits_q [CONTEXTS];
  logic [1:0]          hits_d [CONTEXTS];
  logic [DATA_W-1:0]   best_p_q [CONTEXTS];
  logic [DATA_W-1:0]   best_p_d [CONTEXTS];
  logic [SRC_W-1:0]    best_q [CONTEXTS];
  logic [SRC_W-1:0]    best_d [CONTEXTS];
  logic [CONTEXTS-1:0] nacc_q, nacc_d;
  logic [DATA_W-1:0]   rd_q, rd_d;
  logic                scan_req;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_rd_q;
  logic [CONTEXTS-1:0] out_irq_q;

  // Priority memory.
  logic              ram_we, ram_re;
  logic [SRC_W-1:0]  ram_waddr, ram_raddr, ram_raddr_q;
  logic [DATA_W-1:0] ram_rdata, prio_val;

  // Offset decode.
  logic             is_ctx, ctx_ok, is_en, en_ok, is_pend, pend_ok, prio_ok;
  logic [CTX_W-1:0] ctx_idx, en_ctx;
  logic             en_w, pend_w;
  logic [SRC_W-1:0] s_idx, c_src;
  logic [11:0]      low12;
  logic [31:0]      old_word, off_bits, pend_word;
  logic             found;

  plic_ram #(
    .WIDTH(DATA_W),
    .DEPTH(SOURCES)
  ) u_prio_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wd_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A never-written priority entry reads as zero.
  assign prio_val = prio_vld_q[ram_raddr_q] ? ram_rdata : '0;

  // Register map decode of the captured offset.
  assign is_ctx  = off_q[25:21] != '0;
  assign ctx_ok  = off_q[25:15] == 11'h040;
  assign ctx_idx = off_q[12 +: CTX_W];
  assign low12   = off_q[11:0];
  assign is_en   = off_q[25:13] != '0;
  assign en_ok   = (off_q[25:10] == 16'h0008) && (off_q[6:3] == 4'd0);
  assign en_ctx  = off_q[7 +: CTX_W];
  assign en_w    = off_q[2];
  assign is_pend = off_q[25:12] == 14'd1;
  assign pend_ok = off_q[11:3] == 9'd0;
  assign pend_w  = off_q[2];
  assign prio_ok = (off_q[25:8] == 18'd0) && (off_q[7:2] != 6'd0);
  assign s_idx   = off_q[7:2];
  assign c_src   = wd_q[SRC_W-1:0];

  // Next-state logic for all datapath registers.
  always_comb begin
    prio_vld_d  = prio_vld_q;
    pend_d      = pend_q;
    raised_d    = raised_q;
    en_d        = en_q;
    thr_d       = thr_q;
    line_d      = line_q;
    cnt_d       = cnt_q;
    ev_d        = 1'b0;
    mode_d      = mode_q;
    sc_ctx_d    = sc_ctx_q;
    nmask_d     = nmask_q;
    cmask_d     = cmask_q;
    hits_d      = hits_q;
    best_p_d    = best_p_q;
    best_d      = best_q;
    nacc_d      = nacc_q;
    rd_d        = rd_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = s_idx;
    ram_re      = 1'b0;
    ram_raddr   = s_idx;
    old_word    = en_q[en_ctx][{en_w, 5'd0} +: 32];
    off_bits    = old_word & ~wd_q;
    pend_word   = pend_q[{en_w, 5'd0} +: 32];
    found       = 1'b0;
    scan_req    = 1'b0;

    // Fetch the old priority of the addressed source.
    if (cmd_i.look) begin
      ram_re = 1'b1;
    end

    // Carry out the request's immediate effects and choose a scan.
    if (cmd_i.exec) begin
      rd_d    = '0;
      nmask_d = '0;
      cmask_d = '1;
      unique case (kind_q)
        KIND_READ: begin
          if (is_ctx) begin
            if (ctx_ok && low12 == CTX_THRESHOLD) begin
              rd_d = thr_q[ctx_idx];
            end else if (ctx_ok && low12 == CTX_CLAIM) begin
              scan_req = 1'b1;
              mode_d   = SCAN_CLAIM;
              sc_ctx_d = ctx_idx;
            end
          end else if (is_en) begin
            if (en_ok) begin
              rd_d = old_word;
            end
          end else if (is_pend) begin
            if (pend_ok) begin
              rd_d = pend_q[{pend_w, 5'd0} +: 32];
            end
          end else if (prio_ok) begin
            rd_d = prio_val;
          end
        end
        KIND_WRITE: begin
          if (is_ctx) begin
            if (ctx_ok && low12 == CTX_THRESHOLD) begin
              thr_d[ctx_idx] = wd_q;
              if (thr_q[ctx_idx] != wd_q) begin
                scan_req = 1'b1;
                mode_d   = SCAN_CTX;
                sc_ctx_d = ctx_idx;
              end
            end else if (ctx_ok && low12 == CTX_CLAIM &&
                         wd_q[DATA_W-1:SRC_W] == '0) begin
              if (raised_q[c_src]) begin
                pend_d[c_src]    = 1'b1;
                nmask_d[c_src]   = 1'b1;
                cmask_d          = '0;
                cmask_d[ctx_idx] = 1'b1;
                scan_req         = 1'b1;
                mode_d           = SCAN_NOTIFY;
              end
            end
          end else if (is_en) begin
            if (en_ok) begin
              en_d[en_ctx][{en_w, 5'd0} +: 32] = wd_q;
              if (off_bits != '0) begin
                if ((off_bits & pend_word) != '0) begin
                  scan_req = 1'b1;
                  mode_d   = SCAN_FULL;
                end
              end else if ((wd_q & ~old_word) != '0) begin
                nmask_d[{en_w, 5'd0} +: 32] = pend_word & wd_q;
                scan_req = 1'b1;
                mode_d   = SCAN_NOTIFY;
              end
            end
          end else if (prio_ok) begin
            ram_we            = 1'b1;
            prio_vld_d[s_idx] = 1'b1;
            if (pend_q[s_idx]) begin
              if (wd_q < prio_val) begin
                scan_req = 1'b1;
                mode_d   = SCAN_FULL;
              end else if (wd_q > prio_val) begin
                nmask_d[s_idx] = 1'b1;
                scan_req       = 1'b1;
                mode_d         = SCAN_NOTIFY;
              end
            end
          end
        end
        KIND_LEVEL: begin
          if (src_q != '0) begin
            if (!lvl_q) begin
              raised_d[src_q] = 1'b0;
            end else if (!raised_q[src_q]) begin
              raised_d[src_q] = 1'b1;
              if (!pend_q[src_q]) begin
                pend_d[src_q]  = 1'b1;
                nmask_d[src_q] = 1'b1;
                scan_req       = 1'b1;
                mode_d         = SCAN_NOTIFY;
              end
            end
          end
        end
        default: begin
        end
      endcase
      cnt_d  = '0;
      nacc_d = '0;
      for (int c = 0; c < CONTEXTS; c++) begin
        hits_d[c]   = '0;
        best_p_d[c] = '0;
        best_d[c]   = '0;
      end
    end

    // One source per cycle: issue its priority read, evaluate the previous one.
    if (cmd_i.step) begin
      if (!cnt_q[SRC_W]) begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q[SRC_W-1:0];
        cnt_d     = cnt_q + 1'b1;
        ev_d      = 1'b1;
      end
      if (ev_q) begin
        for (int c = 0; c < CONTEXTS; c++) begin
          if (pend_q[ram_raddr_q] && en_q[c][ram_raddr_q]) begin
            if (prio_val > thr_q[c] && hits_q[c] != 2'd2) begin
              hits_d[c] = hits_q[c] + 2'd1;
            end
            if (prio_val > best_p_q[c]) begin
              best_p_d[c] = prio_val;
              best_d[c]   = ram_raddr_q;
            end
          end
          if (!found && nmask_q[ram_raddr_q] && cmask_q[c] && en_q[c][ram_raddr_q] &&
              prio_val > thr_q[c]) begin
            nacc_d[c] = 1'b1;
            found     = 1'b1;
          end
        end
      end
    end

    // Apply the scan outcome.
    if (cmd_i.finish) begin
      unique case (mode_q)
        SCAN_FULL: begin
          for (int c = 0; c < CONTEXTS; c++) begin
            line_d[c] = hits_q[c] != 2'd0;
          end
        end
        SCAN_CTX: begin
          line_d[sc_ctx_q] = hits_q[sc_ctx_q] != 2'd0;
        end
        SCAN_CLAIM: begin
          line_d[sc_ctx_q] = hits_q[sc_ctx_q][1];
          rd_d             = {{(DATA_W-SRC_W){1'b0}}, best_q[sc_ctx_q]};
          if (best_q[sc_ctx_q] != '0) begin
            pend_d[best_q[sc_ctx_q]] = 1'b0;
          end
        end
        SCAN_NOTIFY: begin
          line_d = line_q | nacc_q;
        end
        default: begin
        end
      endcase
    end

    // Result register handshake.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end
  end

  assign status_o.scan_req  = scan_req;
  assign status_o.scan_done = cnt_q[SRC_W] && !ev_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_vld_q  <= '0;
      pend_q      <= '0;
      raised_q    <= '0;
      line_q      <= '0;
      cnt_q       <= '0;
      ev_q        <= 1'b0;
      mode_q      <= SCAN_FULL;
      out_valid_q <= 1'b0;
      for (int c = 0; c < CONTEXTS; c++) begin
        en_q[c]  <= '0;
        thr_q[c] <= '0;
      end
    end else begin
      prio_vld_q  <= prio_vld_d;
      pend_q      <= pend_d;
      raised_q    <= raised_d;
      line_q      <= line_d;
      cnt_q       <= cnt_d;
      ev_q        <= ev_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
      en_q        <= en_d;
      thr_q       <= thr_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      off_q  <= offset_i;
      wd_q   <= write_data_i;
      src_q  <= source_i;
      lvl_q  <= level_i;
    end
    if (ram_re) begin
      ram_raddr_q <= ram_raddr;
    end
    if (cmd_i.emit) begin
      out_rd_q  <= rd_q;
      out_irq_q <= line_q;
    end
    sc_ctx_q <= sc_ctx_d;
    nmask_q  <= nmask_d;
    cmask_q  <= cmask_d;
    hits_q   <= hits_d;
    best_p_q <= best_p_d;
    best_q   <= best_d;
    nacc_q   <= nacc_d;
    rd_q     <= rd_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_rd_q;
  assign irq_lines_o = out_irq_q;

endmodule

// ===== sv/plic_ctrl.sv =====
// Controller state machine sequencing each request through the datapath.
module plic_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  plic_pkg::status_t status_i,
  output plic_pkg::cmd_t    cmd_o
);
  import plic_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_SCAN,
    ST_FIN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK: state_d = ST_EXEC;
      ST_EXEC: state_d = status_i.scan_req ? ST_SCAN : ST_EMIT;
      ST_SCAN: if (status_i.scan_done) state_d = ST_FIN;
      ST_FIN:  state_d = ST_EMIT;
      ST_EMIT: if (status_i.out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands decoded from the state.
  assign in_ready_o    = state_q == ST_IDLE;
  assign cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.look    = state_q == ST_LOOK;
  assign cmd_o.exec    = state_q == ST_EXEC;
  assign cmd_o.step    = state_q == ST_SCAN;
  assign cmd_o.finish  = state_q == ST_FIN;
  assign cmd_o.emit    = (state_q == ST_EMIT) && status_i.out_free;

endmodule

// ===== sv/platform_interrupt_controller_unit.sv =====
// Top level of the interrupt controller: controller and datapath.
// Each request is a bus read, a bus write or a source level change and yields
// one response with the read data and the interrupt lines after the request.
// Plain register reads and writes and level changes that cause no delivery
// pass through the look, execute and emit states. Claims, completions,
// threshold changes, priority and enable writes that affect pending sources,
// and raises that make a source pending walk all 64 sources through the
// single read port of the priority memory, one source per cycle, with one
// comparator pair per context, in the scan state, then pass the finish and
// emit states. A new request is taken while the previous response still
// waits in the output register.
module platform_interrupt_controller_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [plic_pkg::KIND_W-1:0]    kind_i,
  input  logic [plic_pkg::OFF_W-1:0]     offset_i,
  input  logic [plic_pkg::DATA_W-1:0]    write_data_i,
  input  logic [plic_pkg::SRC_W-1:0]     source_i,
  input  logic                           level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [plic_pkg::DATA_W-1:0]    read_data_o,
  output logic [plic_pkg::CONTEXTS-1:0]  irq_lines_o
);
  import plic_pkg::*;

  cmd_t    cmd;
  status_t status;

  plic_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  plic_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (kind_i),
    .offset_i    (offset_i),
    .write_data_i(write_data_i),
    .source_i    (source_i),
    .level_i     (level_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .read_data_o (read_data_o),
    .irq_lines_o (irq_lines_o)
  );

endmodule

// ===== sv/plic_checker.sv =====
// Port-level checks for the interrupt controller, bound to the top level.
module plic_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [plic_pkg::KIND_W-1:0]    kind_i,
  input logic [plic_pkg::OFF_W-1:0]     offset_i,
  input logic [plic_pkg::DATA_W-1:0]    write_data_i,
  input logic [plic_pkg::SRC_W-1:0]     source_i,
  input logic                           level_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [plic_pkg::DATA_W-1:0]    read_data_o,
  input logic [plic_pkg::CONTEXTS-1:0]  irq_lines_o
);

  // A stalled response holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) &&
    $stable(irq_lines_o))
    else $error("stalled response changed");

  // A waiting request keeps its valid and its payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(kind_i) &&
    $stable(offset_i) && $stable(write_data_i) && $stable(source_i) &&
    $stable(level_i))
    else $error("waiting request changed");

  // One request at a time: the block is busy right after taking one.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // A response never appears in the cycle right after a request.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("response too early");

endmodule

bind platform_interrupt_controller_unit plic_checker u_plic_checker (.*);
